// ----- design/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants of the nine-point stencil
// Sizes, configuration register indexes and the records passed between the
// scan counter, the line store, the window stage and the multiply-add pipe.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int MAX_COLS       = 1024;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_BITS      = 16;
	localparam int COEF_FRAC_BITS = 14;
	localparam int TAPS           = 9;
	localparam int LINE_DEPTH     = MAX_COLS + 2;
	localparam int ADDR_BITS      = $clog2(LINE_DEPTH);

	localparam int CFG_DATA_BITS  = 3 * COEF_BITS;
	localparam int CFG_INDEX_BITS = 3;
	localparam int COL_CFG_BITS   = 11;
	localparam int ROW_CFG_BITS   = 16;
	localparam int ROW_POS_BITS   = ROW_CFG_BITS + 1;
	localparam int OUT_ROW_BITS   = 16;
	localparam int OUT_COL_BITS   = 10;

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	localparam int PART_BITS = PROD_BITS + 2;
	localparam int ACC_BITS  = PROD_BITS + 4;
	localparam int RES_BITS  = ACC_BITS - COEF_FRAC_BITS;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_COEF_TOP    = 3'd0,
		REG_COEF_MIDDLE = 3'd1,
		REG_COEF_BOTTOM = 3'd2,
		REG_COLS        = 3'd3,
		REG_ROWS        = 3'd4
	} cfg_reg_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;

	// coordinates carried with each result
	typedef struct packed {
		logic [OUT_ROW_BITS-1:0] out_row;
		logic [OUT_COL_BITS-1:0] out_col;
		logic                    last;
	} meta_t;

	// placement of one accepted beat in the padded frame
	typedef struct packed {
		logic [COL_CFG_BITS-1:0] col;
		logic                    produce;
		meta_t                   meta;
	} pos_t;

endpackage

// ----- design/stc_scan.sv -----
// ----------------------------------------------------------------------------
// stc_scan: padded-frame position counter
// Places each accepted beat in the padded frame, wraps rows and frames and
// tells whether the beat completes a window over an interior point.
// ----------------------------------------------------------------------------
module stc_scan import stc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [COL_CFG_BITS-1:0] cols,
	input  logic [ROW_CFG_BITS-1:0] rows,
	output pos_t                    pos
);

	logic [COL_CFG_BITS-1:0] col_q;
	logic [ROW_POS_BITS-1:0] row_q;
	logic [COL_CFG_BITS-1:0] cols_eff;
	logic [ROW_POS_BITS-1:0] rows_eff;
	logic [COL_CFG_BITS-1:0] width;
	logic [ROW_POS_BITS-1:0] height;
	logic [COL_CFG_BITS-1:0] c;
	logic [ROW_POS_BITS-1:0] r_wrap;
	logic [ROW_POS_BITS-1:0] r;
	logic [COL_CFG_BITS-1:0] c_dec;
	logic [ROW_POS_BITS-1:0] r_dec;

	// clamp the configured frame size
	always_comb begin
		cols_eff = cols;
		if (cols == '0)
			cols_eff = COL_CFG_BITS'(1);
		else if (cols > COL_CFG_BITS'(MAX_COLS))
			cols_eff = COL_CFG_BITS'(MAX_COLS);
		rows_eff = (rows == '0) ? ROW_POS_BITS'(1) : ROW_POS_BITS'(rows);
		width    = cols_eff + COL_CFG_BITS'(2);
		height   = rows_eff + ROW_POS_BITS'(2);
	end

	// fold a stale position into the current frame size
	always_comb begin
		if (col_q >= width) begin
			c      = '0;
			r_wrap = row_q + ROW_POS_BITS'(1);
		end else begin
			c      = col_q;
			r_wrap = row_q;
		end
		r     = (r_wrap >= height) ? '0 : r_wrap;
		c_dec = c - COL_CFG_BITS'(2);
		r_dec = r - ROW_POS_BITS'(2);
	end

	assign pos.col          = c;
	assign pos.produce      = (r >= ROW_POS_BITS'(2)) && (c >= COL_CFG_BITS'(2));
	assign pos.meta.out_row = r_dec[OUT_ROW_BITS-1:0];
	assign pos.meta.out_col = c_dec[OUT_COL_BITS-1:0];
	assign pos.meta.last    = (r == height - ROW_POS_BITS'(1)) &&
	                          (c == width - COL_CFG_BITS'(1));

	// advance one column per beat, wrap at row and frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c + COL_CFG_BITS'(1) >= width) begin
				col_q <= '0;
				row_q <= (r + ROW_POS_BITS'(1) >= height) ? '0 : r + ROW_POS_BITS'(1);
			end else begin
				col_q <= c + COL_CFG_BITS'(1);
				row_q <= r;
			end
		end
	end

endmodule

// ----- design/stc_line_store.sv -----
// ----------------------------------------------------------------------------
// stc_line_store: storage of the two previous padded rows
// One entry per padded column holds the sample of the row above in the upper
// half and the one two rows above in the lower half. Read data is registered.
// ----------------------------------------------------------------------------
module stc_line_store import stc_pkg::*; (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [ADDR_BITS-1:0]       rd_addr,
	output logic [2*SAMPLE_BITS-1:0]   rd_data,
	input  logic                       wr_en,
	input  logic [ADDR_BITS-1:0]       wr_addr,
	input  logic [2*SAMPLE_BITS-1:0]   wr_data
);

	logic [2*SAMPLE_BITS-1:0] mem_q [LINE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- design/stc_mac.sv -----
// ----------------------------------------------------------------------------
// stc_mac: nine-tap multiply, add, round and saturate pipeline
// Products in the first stage, column partial sums in the second, the total with
// rounding and clipping into the output register in the third.
// ----------------------------------------------------------------------------
module stc_mac import stc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  sample_t taps [TAPS],
	input  coef_t   coefs [TAPS],
	input  meta_t   meta,
	output logic    out_valid,
	input  logic    out_stall,
	output sample_t value,
	output logic    saturated,
	output meta_t   out_meta
);

	localparam logic signed [ACC_BITS-1:0] ROUND = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [RES_BITS-1:0] SAT_HI = RES_BITS'((1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [RES_BITS-1:0] SAT_LO = -SAT_HI - RES_BITS'(1);

	logic                        valid_s2, valid_s3;
	logic                        ld2, ld3, ld4;
	prod_t                       prod_s2 [TAPS];
	meta_t                       meta_s2, meta_s3;
	logic signed [PART_BITS-1:0] part_s3 [3];
	logic signed [ACC_BITS-1:0]  total;
	logic signed [ACC_BITS-1:0]  rounded;
	logic signed [RES_BITS-1:0]  res;

	// a stage loads when empty or when its contents move on
	assign ld4      = !out_valid || !out_stall;
	assign ld3      = !valid_s3 || ld4;
	assign ld2      = !valid_s2 || ld3;
	assign in_ready = ld2;

	// hold stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ld2) valid_s2 <= in_valid;
			if (ld3) valid_s3 <= valid_s2;
			if (ld4) out_valid <= valid_s3;
		end
	end

	// multiply each tap by its weight
	always_ff @(posedge clk) begin
		if (ld2) begin
			for (int k = 0; k < TAPS; k++)
				prod_s2[k] <= taps[k] * coefs[k];
			meta_s2 <= meta;
		end
	end

	// add the products of each window column
	always_ff @(posedge clk) begin
		if (ld3) begin
			for (int j = 0; j < 3; j++)
				part_s3[j] <= PART_BITS'(prod_s2[3*j]) + PART_BITS'(prod_s2[3*j+1]) +
				              PART_BITS'(prod_s2[3*j+2]);
			meta_s3 <= meta_s2;
		end
	end

	// total, round half up, drop fraction bits
	always_comb begin
		total   = ACC_BITS'(part_s3[0]) + ACC_BITS'(part_s3[1]) + ACC_BITS'(part_s3[2]);
		rounded = total + ROUND;
		res     = RES_BITS'(rounded >>> COEF_FRAC_BITS);
	end

	// clip to the sample range into the output register
	always_ff @(posedge clk) begin
		if (ld4) begin
			out_meta <= meta_s3;
			if (res > SAT_HI) begin
				value     <= SAT_HI[SAMPLE_BITS-1:0];
				saturated <= 1'b1;
			end else if (res < SAT_LO) begin
				value     <= SAT_LO[SAMPLE_BITS-1:0];
				saturated <= 1'b1;
			end else begin
				value     <= res[SAMPLE_BITS-1:0];
				saturated <= 1'b0;
			end
		end
	end

endmodule

// ----- design/stencil_nine_point_2d.sv -----
// ----------------------------------------------------------------------------
// stencil_nine_point_2d: streamed 3x3 weighted stencil over a padded grid
// Top level: configuration registers, window stage, line store and MAC pipe.
// ----------------------------------------------------------------------------
// The block takes one padded-grid sample per cycle while the input is not
// stalled and gives one result per interior point, so a frame of
// (cols+2)*(rows+2) beats streams at one beat a clock. After the beat that
// completes a window is accepted, it passes the window stage register, where
// the line store read lands together with the beat, then the multiply,
// column-sum and round/clip stage registers. The line store port, one read and
// one write per padded column, paces the stream at one beat per cycle. A
// stalled output backs up through the pipe, and the input stalls only once
// every stage is full. The line store starts undefined and needs no clearing after reset.
module stencil_nine_point_2d import stc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  sample_t                   sample,
	output logic                      out_valid,
	input  logic                      out_stall,
	output sample_t                   value,
	output logic                      saturated,
	output logic [OUT_ROW_BITS-1:0]   out_row,
	output logic [OUT_COL_BITS-1:0]   out_col,
	output logic                      last
);

	logic [CFG_DATA_BITS-1:0] coef_top_q, coef_mid_q, coef_bot_q;
	logic [COL_CFG_BITS-1:0]  cols_q;
	logic [ROW_CFG_BITS-1:0]  rows_q;

	logic                     accept;
	pos_t                     pos;
	logic                     valid_s1;
	pos_t                     pos_s1;
	sample_t                  sample_s1;
	logic [2*SAMPLE_BITS-1:0] rd_data;
	logic                     leave_s1;
	logic                     mac_ready;
	sample_t                  top, mid;
	sample_t                  win_q [6];
	sample_t                  taps  [TAPS];
	coef_t                    coefs [TAPS];
	meta_t                    out_meta;

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= '0;
			coef_mid_q <= '0;
			coef_bot_q <= '0;
			cols_q     <= COL_CFG_BITS'(MAX_COLS);
			rows_q     <= ROW_CFG_BITS'(1);
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_COEF_TOP:    coef_top_q <= cfg_data;
				REG_COEF_MIDDLE: coef_mid_q <= cfg_data;
				REG_COEF_BOTTOM: coef_bot_q <= cfg_data;
				REG_COLS:        cols_q     <= cfg_data[COL_CFG_BITS-1:0];
				REG_ROWS:        rows_q     <= cfg_data[ROW_CFG_BITS-1:0];
				default:         ;
			endcase
		end
	end

	// input handshake: stall while the window stage cannot move on
	assign leave_s1 = valid_s1 && (!pos_s1.produce || mac_ready);
	assign in_stall = valid_s1 && !leave_s1;
	assign accept   = in_valid && !in_stall;

	stc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cols   (cols_q),
		.rows   (rows_q),
		.pos    (pos)
	);

	// read the column at accept, write it back as the beat leaves the window stage
	stc_line_store u_lines (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (ADDR_BITS'(pos.col)),
		.rd_data (rd_data),
		.wr_en   (leave_s1),
		.wr_addr (ADDR_BITS'(pos_s1.col)),
		.wr_data ({sample_s1, mid})
	);

	assign top = rd_data[SAMPLE_BITS-1:0];
	assign mid = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];

	// hold the window stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (leave_s1)
			valid_s1 <= 1'b0;
	end

	// capture the beat and its position
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			pos_s1    <= pos;
		end
	end

	// shift the window by one column as each beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (leave_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= sample_s1;
		end
	end

	// gather taps by column (left, centre, right), rows top to bottom
	always_comb begin
		taps[0] = win_q[0];
		taps[1] = win_q[1];
		taps[2] = win_q[2];
		taps[3] = win_q[3];
		taps[4] = win_q[4];
		taps[5] = win_q[5];
		taps[6] = top;
		taps[7] = mid;
		taps[8] = sample_s1;
		for (int j = 0; j < 3; j++) begin
			coefs[3*j]   = coef_top_q[j*COEF_BITS +: COEF_BITS];
			coefs[3*j+1] = coef_mid_q[j*COEF_BITS +: COEF_BITS];
			coefs[3*j+2] = coef_bot_q[j*COEF_BITS +: COEF_BITS];
		end
	end

	stc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1 && pos_s1.produce),
		.in_ready  (mac_ready),
		.taps      (taps),
		.coefs     (coefs),
		.meta      (pos_s1.meta),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.saturated (saturated),
		.out_meta  (out_meta)
	);

	assign out_row = out_meta.out_row;
	assign out_col = out_meta.out_col;
	assign last    = out_meta.last;

endmodule

// ----- design/stc_checker.sv -----
// ----------------------------------------------------------------------------
// stc_checker: port-level checks of the stencil block
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module stc_checker import stc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input sample_t                 value,
	input logic                    saturated,
	input logic [OUT_ROW_BITS-1:0] out_row,
	input logic [OUT_COL_BITS-1:0] out_col,
	input logic                    last
);

	localparam sample_t VAL_MAX = sample_t'((1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam sample_t VAL_MIN = ~VAL_MAX;

	// a stalled result beat stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(value) && $stable(saturated) &&
		$stable(out_row) && $stable(out_col) && $stable(last))
		else $error("result payload changed while stalled");

	// a clipped result sits at one end of the sample range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> value == VAL_MAX || value == VAL_MIN)
		else $error("saturated result not at range limit");

	// the input stalls only when the whole pipe is backed up from the output
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// no result beat is offered while reset is applied
	assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result beat offered during reset");

endmodule

bind stencil_nine_point_2d stc_checker u_stc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.value     (value),
	.saturated (saturated),
	.out_row   (out_row),
	.out_col   (out_col),
	.last      (last)
);
